// File: rtl/core/tpspwm_pkg.sv
`default_nettype none
package tpspwm_pkg;

  // Sine table geometry and fixed arithmetic constants
  localparam int unsigned TABLE_SIZE = 360;
  localparam logic [16:0] MOD_M = 17'(100 * TABLE_SIZE);
  localparam logic [8:0]  HALF_IDX = 9'(TABLE_SIZE / 2);
  localparam logic [8:0]  OFF_B = 9'(TABLE_SIZE / 3);
  localparam logic [8:0]  OFF_C = 9'(2 * TABLE_SIZE / 3);
  localparam logic [31:0] REALIGN_TICKS = 32'd12000;
  localparam logic [31:0] HOLD_MAX = 32'd10000;
  localparam logic [14:0] HALF_TURN_TICKS = 15'(50 * TABLE_SIZE);
  localparam logic [8:0]  LOW_HZ = 9'd50;
  // Reciprocals: x/100 for x < 36000, x/25 for x < 150000, x/10 for x < 65536
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam logic [17:0] RECIP_25 = 18'd167773;
  localparam logic [15:0] RECIP_10 = 16'd52429;

  typedef enum logic [2:0] {
    CFG_STEP_COEFF,
    CFG_RAMP_UP_DIV,
    CFG_SLOW_DOWN,
    CFG_DELAY_STEP,
    CFG_PWM_PERIOD,
    CFG_ACCEL_HOLD,
    CFG_DECEL_HOLD,
    CFG_VOLT_DIV
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK, ST_MODA, ST_MUL, ST_IDX, ST_ZERO, ST_DIVT, ST_GAP,
    ST_DIVH, ST_VOLT, ST_DIVV, ST_PH1, ST_PH2, ST_PH3, ST_PH4, ST_OUT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_TICK, OP_MODA, OP_MUL, OP_IDX, OP_ZERO, OP_DIVT,
    OP_GAP, OP_DIVH, OP_VOLT, OP_DIVV, OP_PH1, OP_PH2, OP_PH3, OP_PH4, OP_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic a_ge;
    logic mul_last;
    logic div_tick;
    logic change;
    logic accel;
    logic low_hz;
    logic div_done;
    logic ph_last;
  } dp_stat_t;

  typedef struct packed {
    logic        neg;
    logic [11:0] mag;
  } sine_t;

  localparam logic [11:0] QUARTER_WAVE [0:90] = '{
    12'd0, 12'd52, 12'd105, 12'd157, 12'd209, 12'd261, 12'd314, 12'd366, 12'd418,
    12'd469, 12'd521, 12'd572, 12'd624, 12'd675, 12'd726, 12'd776, 12'd827, 12'd877,
    12'd927, 12'd977, 12'd1026, 12'd1075, 12'd1124, 12'd1172, 12'd1220, 12'd1268,
    12'd1315, 12'd1362, 12'd1408, 12'd1454, 12'd1500, 12'd1545, 12'd1590, 12'd1634,
    12'd1678, 12'd1721, 12'd1763, 12'd1805, 12'd1847, 12'd1888, 12'd1928, 12'd1968,
    12'd2007, 12'd2046, 12'd2084, 12'd2121, 12'd2158, 12'd2194, 12'd2229, 12'd2264,
    12'd2298, 12'd2331, 12'd2364, 12'd2396, 12'd2427, 12'd2457, 12'd2487, 12'd2516,
    12'd2544, 12'd2572, 12'd2598, 12'd2624, 12'd2649, 12'd2673, 12'd2696, 12'd2719,
    12'd2741, 12'd2762, 12'd2782, 12'd2801, 12'd2819, 12'd2837, 12'd2853, 12'd2869,
    12'd2884, 12'd2898, 12'd2911, 12'd2923, 12'd2934, 12'd2945, 12'd2954, 12'd2963,
    12'd2971, 12'd2978, 12'd2984, 12'd2989, 12'd2993, 12'd2996, 12'd2998, 12'd3000,
    12'd3000
  };

  // Full-wave sine as sign and magnitude, folded from the quarter wave
  function automatic sine_t sine_lookup(logic [8:0] idx);
    sine_t      s;
    logic [6:0] q;
    if (idx <= 9'd90) begin
      q = idx[6:0];
    end else if (idx <= HALF_IDX) begin
      q = 7'(HALF_IDX - idx);
    end else if (idx <= 9'd270) begin
      q = 7'(idx - HALF_IDX);
    end else begin
      q = 7'(9'(TABLE_SIZE) - idx);
    end
    s.neg = idx > HALF_IDX;
    s.mag = QUARTER_WAVE[q];
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tpspwm_div.sv
`default_nettype none
module tpspwm_div
  import tpspwm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [14:0] dividend_i,
  input  wire logic [16:0] divisor_i,
  output logic             done_o,
  output logic [14:0]      quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [16:0] rem_q, rem_d;
  logic [14:0] quo_q, quo_d;
  logic [16:0] dvs_q, dvs_d;
  logic [17:0] rem_sh;
  logic        ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, quo_q[14]};
    ge     = rem_sh >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = 4'd14;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 17'(rem_sh - {1'b0, dvs_q}) : rem_sh[16:0];
      quo_d = {quo_q[13:0], ge};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_q && busy_q)
    else $error("divider start did not restart the iteration");

endmodule
`default_nettype wire

// File: rtl/core/tpspwm_dp.sv
`default_nettype none
module tpspwm_dp
  import tpspwm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic [8:0]  target_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic [15:0]      compare_a_o,
  output logic [15:0]      compare_b_o,
  output logic [15:0]      compare_c_o,
  output logic [8:0]       present_frequency_o
);

  // configuration
  logic [7:0]  step_q, step_d;
  logic [15:0] rud_q, rud_d;
  logic [15:0] slow_q, slow_d;
  logic [15:0] dstep_q, dstep_d;
  logic [15:0] period_q, period_d;
  logic [15:0] ahold_q, ahold_d;
  logic [15:0] dhold_q, dhold_d;
  logic [7:0]  vdiv_q, vdiv_d;
  // tick state
  logic [31:0] tick_q, tick_d;
  logic [31:0] hold_q, hold_d;
  logic [8:0]  hz_q, hz_d;
  logic [8:0]  idx_q, idx_d;
  logic [8:0]  target_q, target_d;
  // working registers
  logic [16:0] araw_q, araw_d;
  logic [16:0] a_q, a_d;
  logic [15:0] r_q, r_d;
  logic [4:0]  bit_q, bit_d;
  logic [6:0]  vr_q, vr_d;
  logic [1:0]  ph_q, ph_d;
  logic [18:0] p_q, p_d;
  logic [12:0] qv_q, qv_d;
  logic [15:0] m_q, m_d;
  logic        neg_q, neg_d;
  logic [15:0] cmp_q [0:2];
  logic [15:0] cmp_d [0:2];
  logic [15:0] oa_q, oa_d, ob_q, ob_d, oc_q, oc_d;
  logic [8:0]  of_q, of_d;

  // combinational helpers
  logic [31:0] hold_dec;
  logic [16:0] r2, r2m, rt;
  logic [28:0] idx_prod;
  logic        zero_hit, change, realign, div_tick, accel, high_hz;
  logic [8:0]  gap;
  logic [9:0]  sel_sum;
  logic [8:0]  sel_off, sel_idx;
  sine_t       sv;
  logic [35:0] prod25;
  logic [31:0] prod10;
  logic [12:0] vmag;
  logic signed [17:0] cs;
  logic [15:0] sat;
  logic        div_start, div_done;
  logic [14:0] div_n, quo;
  logic [16:0] div_d;

  // decisions taken at the zero crossing
  always_comb begin
    zero_hit = (idx_q == 9'd0) || (idx_q == HALF_IDX);
    change   = zero_hit && (target_q != hz_q) && (hold_q == 32'd0);
    realign  = zero_hit && ((tick_q >= REALIGN_TICKS) || change);
    div_tick = realign && (idx_q != 9'd0) && (araw_q != 17'd0);
    accel    = target_q > hz_q;
    high_hz  = hz_q > LOW_HZ;
    gap      = accel ? 9'(target_q - hz_q) : 9'(hz_q - target_q);
  end

  // hold countdown and modular product step
  always_comb begin
    hold_dec = (hold_q != 32'd0) ? hold_q - {16'd0, dstep_q} : hold_q;
    if (hold_dec > HOLD_MAX) hold_dec = 32'd0;
    r2       = {r_q, 1'b0};
    r2m      = (r2 >= MOD_M) ? r2 - MOD_M : r2;
    rt       = r2m + (tick_q[bit_q] ? a_q : 17'd0);
    if (rt >= MOD_M) rt = rt - MOD_M;
    idx_prod = 29'(r_q) * 29'(RECIP_100);
  end

  // per-phase amplitude path
  always_comb begin
    unique case (ph_q)
      2'd1:    sel_off = OFF_B;
      2'd2:    sel_off = OFF_C;
      default: sel_off = 9'd0;
    endcase
    sel_sum = {1'b0, idx_q} + {1'b0, sel_off};
    sel_idx = (sel_sum >= 10'(TABLE_SIZE)) ? 9'(sel_sum - 10'(TABLE_SIZE)) : sel_sum[8:0];
    sv      = sine_lookup(sel_idx);
    prod25  = 36'(p_q[18:1]) * 36'(RECIP_25);
    prod10  = 32'(m_q) * 32'(RECIP_10);
    vmag    = prod10[31:19];
    cs      = $signed({3'b000, period_q[15:1]})
            + (neg_q ? -$signed({5'd0, vmag}) : $signed({5'd0, vmag}));
    if (cs < 0) begin
      sat = 16'd0;
    end else if (cs > 18'sd65535) begin
      sat = 16'hFFFF;
    end else begin
      sat = cs[15:0];
    end
  end

  // shared divider operands
  always_comb begin
    div_start = ((cmd_i.op == OP_ZERO) && div_tick)
             || ((cmd_i.op == OP_GAP) && accel)
             || ((cmd_i.op == OP_VOLT) && !high_hz);
    priority case (cmd_i.op)
      OP_ZERO: begin
        div_n = HALF_TURN_TICKS;
        div_d = araw_q;
      end
      OP_GAP: begin
        div_n = 15'(gap);
        div_d = (rud_q == 16'd0) ? 17'd1 : {1'b0, rud_q};
      end
      default: begin
        div_n = 15'(LOW_HZ - hz_q);
        div_d = (vdiv_q == 8'd0) ? 17'd1 : {9'd0, vdiv_q};
      end
    endcase
  end

  tpspwm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // next-state of all registers
  always_comb begin
    step_d = step_q; rud_d = rud_q; slow_d = slow_q; dstep_d = dstep_q;
    period_d = period_q; ahold_d = ahold_q; dhold_d = dhold_q; vdiv_d = vdiv_q;
    tick_d = tick_q; hold_d = hold_q; hz_d = hz_q; idx_d = idx_q; target_d = target_q;
    araw_d = araw_q; a_d = a_q; r_d = r_q; bit_d = bit_q; vr_d = vr_q; ph_d = ph_q;
    p_d = p_q; qv_d = qv_q; m_d = m_q; neg_d = neg_q;
    cmp_d = cmp_q;
    oa_d = oa_q; ob_d = ob_q; oc_d = oc_q; of_d = of_q;

    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_STEP_COEFF:  step_d   = cfg_data_i[7:0];
        CFG_RAMP_UP_DIV: rud_d    = cfg_data_i;
        CFG_SLOW_DOWN:   slow_d   = cfg_data_i;
        CFG_DELAY_STEP:  dstep_d  = cfg_data_i;
        CFG_PWM_PERIOD:  period_d = cfg_data_i;
        CFG_ACCEL_HOLD:  ahold_d  = cfg_data_i;
        CFG_DECEL_HOLD:  dhold_d  = cfg_data_i;
        CFG_VOLT_DIV:    vdiv_d   = cfg_data_i[7:0];
      endcase
    end

    case (cmd_i.op)
      OP_LATCH: target_d = target_i;
      OP_TICK: begin
        tick_d = tick_q + 32'd1;
        hold_d = hold_dec;
        araw_d = 17'(step_q) * 17'(hz_q);
        a_d    = 17'(step_q) * 17'(hz_q);
      end
      OP_MODA: begin
        if (a_q >= MOD_M) begin
          a_d = a_q - MOD_M;
        end else begin
          r_d   = '0;
          bit_d = 5'd31;
        end
      end
      OP_MUL: begin
        r_d   = rt[15:0];
        bit_d = bit_q - 5'd1;
      end
      OP_IDX: idx_d = idx_prod[27:19];
      OP_ZERO: begin
        if (realign && ((idx_q == 9'd0) || (araw_q == 17'd0))) tick_d = 32'd0;
      end
      OP_DIVT: if (div_done) tick_d = {17'd0, quo};
      OP_GAP: begin
        if (!accel) begin
          hold_d = 32'(25'(gap) * 25'(slow_q)) + {16'd0, dhold_q};
          hz_d   = hz_q - 9'd1;
        end
      end
      OP_DIVH: begin
        if (div_done) begin
          hold_d = {17'd0, quo} + {16'd0, ahold_q};
          hz_d   = hz_q + 9'd1;
        end
      end
      OP_VOLT: ph_d = 2'd0;
      OP_DIVV: if (div_done) vr_d = 7'(hz_q) + quo[6:0];
      OP_PH1: begin
        neg_d = sv.neg;
        p_d   = high_hz ? {7'd0, sv.mag} : 19'(sv.mag) * 19'(vr_q);
      end
      OP_PH2: qv_d = high_hz ? p_q[12:0] : prod25[34:22];
      OP_PH3: m_d = 16'(qv_q) * 16'd9;
      OP_PH4: begin
        cmp_d[ph_q] = sat;
        ph_d        = ph_q + 2'd1;
      end
      OP_LOAD: begin
        oa_d = cmp_q[0];
        ob_d = cmp_q[1];
        oc_d = cmp_q[2];
        of_d = hz_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= 8'd1;
      rud_q    <= 16'd1;
      slow_q   <= 16'd1;
      dstep_q  <= 16'd1;
      period_q <= 16'd6000;
      ahold_q  <= '0;
      dhold_q  <= '0;
      vdiv_q   <= 8'd1;
      tick_q   <= '0;
      hold_q   <= '0;
      hz_q     <= '0;
      idx_q    <= '0;
      r_q      <= '0;
      ph_q     <= '0;
      bit_q    <= '0;
    end else begin
      step_q   <= step_d;
      rud_q    <= rud_d;
      slow_q   <= slow_d;
      dstep_q  <= dstep_d;
      period_q <= period_d;
      ahold_q  <= ahold_d;
      dhold_q  <= dhold_d;
      vdiv_q   <= vdiv_d;
      tick_q   <= tick_d;
      hold_q   <= hold_d;
      hz_q     <= hz_d;
      idx_q    <= idx_d;
      r_q      <= r_d;
      ph_q     <= ph_d;
      bit_q    <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    araw_q   <= araw_d;
    a_q      <= a_d;
    vr_q     <= vr_d;
    p_q      <= p_d;
    qv_q     <= qv_d;
    m_q      <= m_d;
    neg_q    <= neg_d;
    cmp_q    <= cmp_d;
    oa_q     <= oa_d;
    ob_q     <= ob_d;
    oc_q     <= oc_d;
    of_q     <= of_d;
  end

  always_comb begin
    stat_o.a_ge     = a_q >= MOD_M;
    stat_o.mul_last = bit_q == 5'd0;
    stat_o.div_tick = div_tick;
    stat_o.change   = change;
    stat_o.accel    = accel;
    stat_o.low_hz   = !high_hz;
    stat_o.div_done = div_done;
    stat_o.ph_last  = ph_q == 2'd2;
  end

  assign compare_a_o         = oa_q;
  assign compare_b_o         = ob_q;
  assign compare_c_o         = oc_q;
  assign present_frequency_o = of_q;

  a_residue_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_q < MOD_M[15:0])
    else $error("phase residue out of range");

  a_index_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < 9'(TABLE_SIZE))
    else $error("phase index out of table");

endmodule
`default_nettype wire

// File: rtl/core/tpspwm_ctrl.sv
`default_nettype none
module tpspwm_ctrl
  import tpspwm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_TICK;
      ST_TICK: state_d = ST_MODA;
      ST_MODA: if (!stat_i.a_ge) state_d = ST_MUL;
      ST_MUL:  if (stat_i.mul_last) state_d = ST_IDX;
      ST_IDX:  state_d = ST_ZERO;
      ST_ZERO: begin
        if (stat_i.div_tick) state_d = ST_DIVT;
        else if (stat_i.change) state_d = ST_GAP;
        else state_d = ST_VOLT;
      end
      ST_DIVT: if (stat_i.div_done) state_d = stat_i.change ? ST_GAP : ST_VOLT;
      ST_GAP:  state_d = stat_i.accel ? ST_DIVH : ST_VOLT;
      ST_DIVH: if (stat_i.div_done) state_d = ST_VOLT;
      ST_VOLT: state_d = stat_i.low_hz ? ST_DIVV : ST_PH1;
      ST_DIVV: if (stat_i.div_done) state_d = ST_PH1;
      ST_PH1:  state_d = ST_PH2;
      ST_PH2:  state_d = ST_PH3;
      ST_PH3:  state_d = ST_PH4;
      ST_PH4:  state_d = stat_i.ph_last ? ST_OUT : ST_PH1;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
    endcase
  end

  // datapath command per state
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LATCH;
      end
      ST_TICK: cmd_o.op = OP_TICK;
      ST_MODA: cmd_o.op = OP_MODA;
      ST_MUL:  cmd_o.op = OP_MUL;
      ST_IDX:  cmd_o.op = OP_IDX;
      ST_ZERO: cmd_o.op = OP_ZERO;
      ST_DIVT: cmd_o.op = OP_DIVT;
      ST_GAP:  cmd_o.op = OP_GAP;
      ST_DIVH: cmd_o.op = OP_DIVH;
      ST_VOLT: cmd_o.op = OP_VOLT;
      ST_DIVV: cmd_o.op = OP_DIVV;
      ST_PH1:  cmd_o.op = OP_PH1;
      ST_PH2:  cmd_o.op = OP_PH2;
      ST_PH3:  cmd_o.op = OP_PH3;
      ST_PH4:  cmd_o.op = OP_PH4;
      ST_OUT:  if (out_free) cmd_o.op = OP_LOAD;
    endcase
  end

  // output beat holding register
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == ST_OUT) && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_presents_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) && out_free |=> out_valid_q && (state_q == ST_IDLE))
    else $error("result load did not present a beat");

endmodule
`default_nettype wire

// File: rtl/core/three_phase_sine_pwm_vf_ramp.sv
// Processing: each accepted input beat runs the 32-step modular product and up to three
//   passes of the shared divider before its result beat is loaded.
// Flow: one item at a time; the next input beat is taken when the controller is back
//   in idle, while the previous result may still wait in the output register.
// Reset (rst_ni low, asynchronous): registers with a reset load their reset values, ramp state
//   clears, no result is pending; the sine table is constant logic.
`default_nettype none
module three_phase_sine_pwm_vf_ramp
  import tpspwm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [8:0] target_frequency, [15:9] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] compare_a, [31:16] compare_b, [47:32] compare_c,
  // [56:48] present_frequency, [63:57] zero
  output logic [63:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [15:0] cmp_a, cmp_b, cmp_c;
  logic [8:0]  freq;

  assign cfg_ready_o = 1'b1;

  tpspwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tpspwm_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .target_i            (s_axis_tdata[8:0]),
    .cfg_we_i            (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .compare_a_o         (cmp_a),
    .compare_b_o         (cmp_b),
    .compare_c_o         (cmp_c),
    .present_frequency_o (freq)
  );

  // pack result beat
  assign m_axis_tdata = {7'd0, freq, cmp_c, cmp_b, cmp_a};

endmodule
`default_nettype wire
